// ===== rtl/fric_pkg.sv =====
`timescale 1ns / 1ps
// Package for the FIFO-replacement identifier cache.
// Beat types for the input and result channels, the op codes and the cell command.
package fric_pkg;

	localparam int ID_W  = 32;
	localparam int CNT_W = 5;
	localparam int CAP_W = 5;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// input beat
	typedef struct packed {
		logic            op;
		logic [ID_W-1:0] ident;
	} in_t;

	// result beat
	typedef struct packed {
		logic             hit;
		logic             evicted_valid;
		logic [ID_W-1:0]  evicted_ident;
		logic [CNT_W-1:0] entry_count;
		logic             read_valid;
		logic [ID_W-1:0]  read_ident;
		logic             last;
	} out_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic ins;  // insert a new identifier at the head, older ones move down
		logic app;  // insert also grows the row by one cell
		logic rot;  // readout rotation toward the head
	} cell_cmd_t;

endpackage

// ===== rtl/fifo_replacement_id_cache.sv =====
`timescale 1ns / 1ps
// Top level of the FIFO-replacement identifier cache: control, row of cells, result register.
// Depends on fric_pkg and fric_cell.
//
//  channel  | handshake            | beat
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_stall  | in_data  (op, ident)
//  out      | out_valid / out_stall| out_data (hit .. last)
//  cfg      | cfg_valid / cfg_ready| cfg_data (capacity)
//
// An access runs in three steps: take the beat, compare in all cells and register
// hit and victim, then update the row and load the result register.
// A readout gives one result per held entry (at least one result);
// cell 0 is the newest entry and the row rotates one cell per result beat.
// Reset clears all valid bits and the count and sets the capacity to 16, all at once.
// A stalled result holds the result register; the next input beat is still taken.
module fifo_replacement_id_cache #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  fric_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output fric_pkg::out_t                 out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fric_pkg::CAP_W-1:0]     cfg_data
);

	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int IDW  = fric_pkg::ID_W;
	localparam int CNTW = fric_pkg::CNT_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_UPD  = 4'b0100,
		S_READ = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [fric_pkg::CAP_W-1:0]  cap_q;
	logic [CW-1:0]               held_q;
	logic [CW-1:0]               rd_left_q;
	logic [CW-1:0]               eff_cap;
	logic [CW-1:0]               held_after;
	logic [IDW-1:0]              id_q;
	logic                        hit_q;
	logic [IDW-1:0]              victim_q;
	logic                        out_valid_q;
	fric_pkg::out_t              out_q;
	fric_pkg::out_t              res;
	fric_pkg::cell_cmd_t         cmd;

	logic [IDW-1:0]              cell_data [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]      cell_valid;
	logic [MAX_ENTRIES-1:0]      cell_match;
	logic [MAX_ENTRIES-1:0]      cell_tail;

	logic                        out_free;
	logic                        append;
	logic                        emit;
	logic                        hit_any;
	logic [IDW-1:0]              victim_any;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= fric_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// clamp capacity to 1..MAX_ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (int'(cap_q) > MAX_ENTRIES) begin
			eff_cap = CW'(MAX_ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	assign append     = (held_q < eff_cap);
	assign held_after = (!hit_q && append) ? CW'(held_q + 1'b1) : held_q;

	// row-wide reductions: any match, and the identifier in the tail cell
	always_comb begin
		hit_any    = |cell_match;
		victim_any = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			victim_any = victim_any | (cell_tail[i] ? cell_data[i] : '0);
		end
	end

	// row of cells, cell 0 holds the newest identifier
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [IDW-1:0] prev_data;
		logic           prev_valid;
		logic [IDW-1:0] next_data;
		logic           next_valid;

		if (i == 0) begin : g_head
			assign prev_data  = id_q;
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_data  = cell_data[i-1];
			assign prev_valid = cell_valid[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_end
			assign next_data  = '0;
			assign next_valid = 1'b0;
		end else begin : g_mid
			assign next_data  = cell_data[i+1];
			assign next_valid = cell_valid[i+1];
		end

		fric_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.key        (id_q),
			.prev_data  (prev_data),
			.prev_valid (prev_valid),
			.next_data  (next_data),
			.next_valid (next_valid),
			.head_data  (cell_data[0]),
			.data       (cell_data[i]),
			.valid      (cell_valid[i]),
			.match      (cell_match[i]),
			.tail       (cell_tail[i])
		);
	end

	// cell command and result beat
	always_comb begin
		cmd  = '0;
		res  = '0;
		emit = 1'b0;
		unique case (state_q)
			S_UPD: begin
				emit              = out_free;
				cmd.ins           = out_free && !hit_q;
				cmd.app           = append;
				res.hit           = hit_q;
				res.evicted_valid = !hit_q && !append;
				res.evicted_ident = (!hit_q && !append) ? victim_q : '0;
				res.entry_count   = CNTW'(held_after);
				res.last          = 1'b1;
			end
			S_READ: begin
				emit            = out_free;
				cmd.rot         = out_free && (rd_left_q != '0);
				res.entry_count = CNTW'(held_q);
				res.read_valid  = (rd_left_q != '0);
				res.read_ident  = (rd_left_q != '0) ? cell_data[0] : '0;
				res.last        = (rd_left_q <= CW'(1));
			end
			S_IDLE, S_LOOK: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer, count and readout counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			held_q    <= '0;
			rd_left_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rd_left_q <= held_q;
						state_q   <= (in_data.op == fric_pkg::OP_READ) ? S_READ : S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (out_free) begin
						held_q  <= held_after;
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (out_free) begin
						if (rd_left_q != '0) begin
							rd_left_q <= CW'(rd_left_q - 1'b1);
						end
						if (rd_left_q <= CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// key, compare outcome and victim
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			id_q <= in_data.ident;
		end
		if (state_q == S_LOOK) begin
			hit_q    <= hit_any;
			victim_q <= victim_any;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

endmodule

// ===== rtl/fric_cell.sv =====
`timescale 1ns / 1ps
// One cell of the identifier row: holds one identifier and its valid bit.
// Depends on fric_pkg for the cell command and the identifier width.
module fric_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fric_pkg::cell_cmd_t         cmd,
	input  logic [fric_pkg::ID_W-1:0]   key,
	input  logic [fric_pkg::ID_W-1:0]   prev_data,
	input  logic                        prev_valid,
	input  logic [fric_pkg::ID_W-1:0]   next_data,
	input  logic                        next_valid,
	input  logic [fric_pkg::ID_W-1:0]   head_data,
	output logic [fric_pkg::ID_W-1:0]   data,
	output logic                        valid,
	output logic                        match,
	output logic                        tail
);

	logic [fric_pkg::ID_W-1:0] data_q;
	logic                      valid_q;

	// valid bit: set when the row grows into this cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins && cmd.app && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	// identifier: shift away from the head on insert, toward it on rotate
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (valid_q || (cmd.app && prev_valid)) begin
				data_q <= prev_data;
			end
		end else if (cmd.rot && valid_q) begin
			data_q <= next_valid ? next_data : head_data;
		end
	end

	assign data  = data_q;
	assign valid = valid_q;
	assign match = valid_q && (data_q == key);
	assign tail  = valid_q && !next_valid;

endmodule
